### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the core.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define KCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define KCD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

### rtl/core/kcd_pkg.sv
// Package for the key combination detector: sizes, register indexes,
// microcode word layout and the microcode program. No dependencies.
package kcd_pkg;

    localparam int NUM_COMBOS     = 7;
    localparam int KEYS_PER_COMBO = 4;
    localparam int HELD_DEPTH     = 8;
    localparam int COMBO_REGS     = 7;
    localparam int COMBO_SLOTS    = 4;
    localparam int KEY_W          = 8;
    localparam int TIME_W         = 32;
    localparam int TMO_W          = 16;
    localparam int LEN_W          = 3;
    localparam int COMBO_W        = COMBO_SLOTS * KEY_W + LEN_W;
    localparam int CFG_W          = COMBO_W;
    localparam int CFG_IDX_W      = 3;
    localparam int COMBO_IDX_W    = 3;
    localparam int HELD_IDX_W     = $clog2(HELD_DEPTH);
    localparam int CNT_W          = $clog2(HELD_DEPTH + 1);
    localparam int STEP_W         = 3;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd300;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO0  = 3'd1;

    // Program steps
    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_TMO   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_HELD  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ELIG  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_STORE = 3'd4;
    localparam logic [STEP_W-1:0] STEP_MATCH = 3'd5;

    typedef enum logic [2:0] {
        COND_NONE  = 3'd0,
        COND_START = 3'd1,
        COND_TMO   = 3'd2,
        COND_HELD  = 3'd3,
        COND_ELIG  = 3'd4,
        COND_FULL  = 3'd5,
        COND_MATCH = 3'd6
    } cond_t;

    // One control word. *_t acts when the condition is true, *_f when false
    // and the scan (if any) has reached the last combination.
    typedef struct packed {
        cond_t             cond;
        logic              scan;
        logic              ld_t;
        logic              clr_t;
        logic              clr_f;
        logic              store_f;
        logic              emit_t;
        logic              rst_c;
        logic [STEP_W-1:0] jt;
        logic [STEP_W-1:0] jf;
    } ucode_t;

    typedef struct packed {
        logic elig;
        logic equal;
    } eval_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uw;
        uw = '0;
        uw.cond = COND_NONE;
        uw.jt   = STEP_IDLE;
        uw.jf   = STEP_IDLE;
        case (step)
            STEP_IDLE:
            begin
                uw.cond  = COND_START;
                uw.ld_t  = 1'b1;
                uw.rst_c = 1'b1;
                uw.jt    = STEP_TMO;
                uw.jf    = STEP_IDLE;
            end
            STEP_TMO:
            begin
                uw.cond  = COND_TMO;
                uw.clr_t = 1'b1;
                uw.jt    = STEP_HELD;
                uw.jf    = STEP_HELD;
            end
            STEP_HELD:
            begin
                uw.cond  = COND_HELD;
                uw.rst_c = 1'b1;
                uw.jt    = STEP_IDLE;
                uw.jf    = STEP_ELIG;
            end
            STEP_ELIG:
            begin
                uw.cond  = COND_ELIG;
                uw.scan  = 1'b1;
                uw.clr_f = 1'b1;
                uw.jt    = STEP_STORE;
                uw.jf    = STEP_IDLE;
            end
            STEP_STORE:
            begin
                uw.cond    = COND_FULL;
                uw.clr_t   = 1'b1;
                uw.store_f = 1'b1;
                uw.rst_c   = 1'b1;
                uw.jt      = STEP_IDLE;
                uw.jf      = STEP_MATCH;
            end
            STEP_MATCH:
            begin
                uw.cond   = COND_MATCH;
                uw.scan   = 1'b1;
                uw.clr_t  = 1'b1;
                uw.emit_t = 1'b1;
                uw.jt     = STEP_IDLE;
                uw.jf     = STEP_IDLE;
            end
            default:
            begin
                uw.cond = COND_NONE;
                uw.jf   = STEP_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

### rtl/core/kcd_combo_eval.sv
// Evaluates one combination against the held list and the pending key.
// Depends on kcd_pkg.
module kcd_combo_eval
    import kcd_pkg::*;
(
    input  logic [COMBO_W-1:0]                combo,
    input  logic [HELD_DEPTH-1:0][KEY_W-1:0]  held,
    input  logic [CNT_W-1:0]                  held_count,
    input  logic [KEY_W-1:0]                  key,
    output eval_t                             result
);

    logic [LEN_W-1:0]       len_raw;
    logic [LEN_W-1:0]       len_sat;
    logic [COMBO_SLOTS-1:0] slot_ok;
    logic [HELD_DEPTH-1:0]  held_ok;
    logic [COMBO_SLOTS-1:0] key_in_combo;
    logic                   touches;
    logic [HELD_DEPTH-1:0]  held_covered;
    logic [COMBO_SLOTS-1:0] slot_covered;
    logic [KEY_W-1:0]       ckey [COMBO_SLOTS];
    logic                   hit;

    assign len_raw = combo[COMBO_W-1 -: LEN_W];
    assign len_sat = (len_raw > LEN_W'(KEYS_PER_COMBO)) ? LEN_W'(KEYS_PER_COMBO) : len_raw;

    always_comb
    begin
        touches      = 1'b0;
        held_covered = '0;
        slot_covered = '0;
        hit          = 1'b0;
        for (int j = 0; j < COMBO_SLOTS; j++)
        begin
            ckey[j]         = combo[j*KEY_W +: KEY_W];
            slot_ok[j]      = LEN_W'(j) < len_sat;
            key_in_combo[j] = slot_ok[j] && (ckey[j] == key);
        end
        for (int i = 0; i < HELD_DEPTH; i++)
        begin
            held_ok[i] = CNT_W'(i) < held_count;
        end
        for (int i = 0; i < HELD_DEPTH; i++)
        begin
            for (int j = 0; j < COMBO_SLOTS; j++)
            begin
                hit = held_ok[i] && slot_ok[j] && (held[i] == ckey[j]);
                if (hit)
                begin
                    touches         = 1'b1;
                    held_covered[i] = 1'b1;
                    slot_covered[j] = 1'b1;
                end
            end
        end
        result.elig  = (len_sat != '0) && (|key_in_combo) &&
                       ((held_count == '0) || touches);
        result.equal = (len_sat != '0) && (&(held_covered | ~held_ok)) &&
                       (&(slot_covered | ~slot_ok));
    end

endmodule

### rtl/core/key_combination_detector_core.sv
// Top level of the key combination detector: microcode sequencer, held-key
// list and configuration registers. Depends on kcd_pkg and kcd_combo_eval.
//
// Usage:
//   Input: drive key_code and press_time_ms and raise start; the transaction
//   is taken at a rising edge with start high and busy low. busy then stays
//   high while the item is worked on.
//   Result: when the held keys form a configured combination, combo_valid is
//   high for exactly one cycle with combo_index; the receiver cannot stall,
//   so it must take the result in that cycle. Most presses give no result.
//   Sequence: for a repeated key, busy covers the timeout and held-list
//   steps; for a new key it also covers the eligibility scan and, if a
//   combination is eligible, the store step and the match scan. The next
//   transaction can be taken in the first cycle with busy low. The shared
//   evaluation unit checks one combination per cycle, first for eligibility,
//   then for a full match. combo_valid shows in the cycle after the matching step.
//   Configuration: cfg_we / cfg_index / cfg_data, written while busy is low.
//   Index 0 is the timeout limit, indexes 1..7 are the seven combinations.
//   Reset: asynchronous rst_n empties the held list, sets the timeout limit
//   to 300 ms, disables every combination and returns the sequencer to idle.
module key_combination_detector_core
    import kcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [KEY_W-1:0]       key_code,
    input  logic [TIME_W-1:0]      press_time_ms,
    output logic                   combo_valid,
    output logic [COMBO_IDX_W-1:0] combo_index,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    // Sequencer state
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [COMBO_IDX_W-1:0] sel_reg, sel_next;
    ucode_t                 uw;
    logic                   cond;
    logic                   last_combo;

    // Datapath
    logic [CNT_W-1:0]               held_count_reg, held_count_next;
    logic [HELD_DEPTH-1:0][KEY_W-1:0] held_keys_reg;
    logic [TIME_W-1:0]              last_time_reg;
    logic [KEY_W-1:0]               key_reg;
    logic [TIME_W-1:0]              time_reg;
    logic                           load_in;
    logic                           store_key;
    logic                           valid_next;

    // Configuration
    logic [TMO_W-1:0]   timeout_reg;
    logic [COMBO_W-1:0] combo_reg [COMBO_REGS];

    // Conditions
    logic [TIME_W-1:0] gap;
    logic              tmo_hit;
    logic              key_held;
    eval_t             ev;

    logic                   combo_valid_reg;
    logic [COMBO_IDX_W-1:0] combo_index_reg;

    assign uw         = ucode_rom(step_reg);
    assign busy       = (step_reg != STEP_IDLE);
    assign last_combo = (sel_reg == COMBO_IDX_W'(NUM_COMBOS - 1));

    // timeout: gap taken modulo 2^32, only with a non-empty list
    assign gap     = time_reg - last_time_reg;
    assign tmo_hit = (held_count_reg != '0) && (gap > TIME_W'(timeout_reg));

    always_comb
    begin
        key_held = 1'b0;
        for (int i = 0; i < HELD_DEPTH; i++)
        begin
            if ((CNT_W'(i) < held_count_reg) && (held_keys_reg[i] == key_reg))
            begin
                key_held = 1'b1;
            end
        end
    end

    kcd_combo_eval u_eval (
        .combo      (combo_reg[sel_reg]),
        .held       (held_keys_reg),
        .held_count (held_count_reg),
        .key        (key_reg),
        .result     (ev)
    );

    // condition select of the current control word
    always_comb
    begin
        case (uw.cond)
            COND_START: cond = start;
            COND_TMO:   cond = tmo_hit;
            COND_HELD:  cond = key_held;
            COND_ELIG:  cond = ev.elig;
            COND_FULL:  cond = (held_count_reg >= CNT_W'(HELD_DEPTH));
            COND_MATCH: cond = ev.equal;
            default:    cond = 1'b0;
        endcase
    end

    // step sequencing: jump on true, scan on false until the last combo,
    // then take the false jump
    always_comb
    begin
        step_next       = step_reg;
        sel_next        = sel_reg;
        held_count_next = held_count_reg;
        valid_next      = 1'b0;
        load_in         = 1'b0;
        store_key       = 1'b0;
        if (cond)
        begin
            step_next = uw.jt;
            load_in   = uw.ld_t;
            if (uw.clr_t)
            begin
                held_count_next = '0;
            end
            valid_next = uw.emit_t;
        end
        else if (uw.scan && !last_combo)
        begin
            sel_next = sel_reg + COMBO_IDX_W'(1);
        end
        else
        begin
            step_next = uw.jf;
            if (uw.clr_f)
            begin
                held_count_next = '0;
            end
            if (uw.store_f)
            begin
                store_key       = 1'b1;
                held_count_next = held_count_reg + CNT_W'(1);
            end
        end
        if (uw.rst_c)
        begin
            sel_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= STEP_IDLE;
            sel_reg         <= '0;
            held_count_reg  <= '0;
            last_time_reg   <= '0;
            combo_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg        <= step_next;
            sel_reg         <= sel_next;
            held_count_reg  <= held_count_next;
            combo_valid_reg <= valid_next;
            if (store_key)
            begin
                last_time_reg <= time_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            key_reg  <= key_code;
            time_reg <= press_time_ms;
        end
        if (store_key)
        begin
            held_keys_reg[held_count_reg[HELD_IDX_W-1:0]] <= key_reg;
        end
        if (valid_next)
        begin
            combo_index_reg <= sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            for (int c = 0; c < COMBO_REGS; c++)
            begin
                combo_reg[c] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg_data[TMO_W-1:0];
            end
            else
            begin
                combo_reg[CFG_IDX_W'(cfg_index - REG_COMBO0)] <= cfg_data;
            end
        end
    end

    assign combo_valid = combo_valid_reg;
    assign combo_index = combo_index_reg;

endmodule

### rtl/core/kcd_checker.sv
// Port-level checker for key_combination_detector_core, bound to the top.
// Depends on kcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kcd_checker
    import kcd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic [KEY_W-1:0]       key_code,
    input logic [TIME_W-1:0]      press_time_ms,
    input logic                   combo_valid,
    input logic [COMBO_IDX_W-1:0] combo_index,
    input logic                   cfg_we,
    input logic [CFG_IDX_W-1:0]   cfg_index,
    input logic [CFG_W-1:0]       cfg_data
);

    // an accepted transaction makes the block busy in the next cycle
    `KCD_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // a result comes only at the end of work
    `KCD_ASSERT_IMP(a_result_idle, combo_valid, !busy && $past(busy))
    // one result per item, strobe is a single cycle
    `KCD_ASSERT_NXT(a_single_strobe, combo_valid, !combo_valid)
    `KCD_ASSERT_IMP(a_index_range, combo_valid, combo_index < COMBO_IDX_W'(NUM_COMBOS))

endmodule

bind key_combination_detector_core kcd_checker u_kcd_checker (.*);
